>>> design/irc_message_line_parser_assert.svh
// Assertion macros for the IRC message line parser.
// Each macro places one labeled concurrent assertion, clocked on clk and
// disabled while rst is high.
`ifndef IRC_MESSAGE_LINE_PARSER_ASSERT_SVH
`define IRC_MESSAGE_LINE_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irc parser: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irc parser: next-cycle check failed");

`endif

>>> design/irc_pkg.sv
// ----------------------------------------------------------------------------
// irc_pkg
// Types and constants shared by the IRC message line parser modules.
// ----------------------------------------------------------------------------
package irc_pkg;

  // Reset value of the line length limit.
  localparam logic [9:0] MAX_LEN_RESET = 10'd512;

  // Operation codes of an input item.
  localparam logic OP_FEED  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Parse phases.
  typedef enum logic [2:0] {
    PH_BEGIN   = 3'd0,
    PH_PREFIX  = 3'd1,
    PH_COMMAND = 3'd2,
    PH_PSTART  = 3'd3,
    PH_PARAM   = 3'd4,
    PH_TSTART  = 3'd5,
    PH_TRAIL   = 3'd6,
    PH_LF      = 3'd7
  } phase_t;

  // Reported parse status.
  typedef enum logic [1:0] {
    ST_CONT = 2'd0,
    ST_DONE = 2'd1,
    ST_FAIL = 2'd2
  } status_t;

  // Token kinds.
  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_PREFIX  = 3'd1,
    KIND_COMMAND = 3'd2,
    KIND_MIDDLE  = 3'd3,
    KIND_TRAIL   = 3'd4
  } kind_t;

  // Parser state carried from one item to the next.
  typedef struct packed {
    phase_t      phase;
    logic [9:0]  byte_count;
    logic [7:0]  param_count;
    status_t     final_status;
  } parse_state_t;

  // One result item.
  typedef struct packed {
    status_t     status;
    kind_t       kind;
    logic        start;
    logic        stop;
    logic [7:0]  param_index;
    logic [9:0]  position;
  } parse_result_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:        PH_BEGIN,
    byte_count:   10'd0,
    param_count:  8'd0,
    final_status: ST_CONT
  };

endpackage

>>> design/irc_step.sv
// ----------------------------------------------------------------------------
// irc_step
// Combinational transition of the parser for one item: next state and the
// result fields, from the current state, the item and the length limit.
// ----------------------------------------------------------------------------
module irc_step import irc_pkg::*; (
  input  parse_state_t  cur,
  input  logic          op,
  input  logic [7:0]    data_byte,
  input  logic [9:0]    limit,
  output parse_state_t  nxt,
  output parse_result_t res
);

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] PC_MAX   = 8'hFF;

  logic fail;
  logic alnum;
  logic regular;
  logic [7:0] last_param;

  // Character classes of the incoming byte.
  assign alnum = (data_byte >= 8'h30 && data_byte <= 8'h39) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h5A) ||
                 (data_byte >= 8'h61 && data_byte <= 8'h7A);
  assign regular = (data_byte != CH_NUL) && (data_byte != CH_SPACE) &&
                   (data_byte != CH_CR) && (data_byte != CH_LF);

  // Index of the parameter currently being read.
  assign last_param = (cur.param_count != 8'd0) ? cur.param_count - 8'd1 : 8'd0;

  // State transition and result fields.
  always_comb begin
    nxt             = cur;
    fail            = 1'b0;
    res.status      = ST_CONT;
    res.kind        = KIND_NONE;
    res.start       = 1'b0;
    res.stop        = 1'b0;
    res.param_index = 8'd0;
    res.position    = cur.byte_count;

    if (op == OP_CLEAR) begin
      nxt          = STATE_CLEAR;
      res.position = 10'd0;
    end else if (cur.final_status != ST_CONT) begin
      res.status = cur.final_status;
    end else if (cur.byte_count >= limit) begin
      fail = 1'b1;
    end else begin
      nxt.byte_count = cur.byte_count + 10'd1;
      unique case (cur.phase)
        PH_BEGIN: begin
          if (data_byte == CH_COLON && cur.byte_count == 10'd0) begin
            res.kind = KIND_PREFIX; res.start = 1'b1; nxt.phase = PH_PREFIX;
          end else if (alnum) begin
            res.kind = KIND_COMMAND; res.start = 1'b1; nxt.phase = PH_COMMAND;
          end else begin
            fail = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (data_byte == CH_SPACE) begin
            res.kind = KIND_PREFIX; res.stop = 1'b1; nxt.phase = PH_BEGIN;
          end else if (regular) begin
            res.kind = KIND_PREFIX;
          end else begin
            fail = 1'b1;
          end
        end
        PH_COMMAND: begin
          if (data_byte == CH_SPACE) begin
            res.kind = KIND_COMMAND; res.stop = 1'b1; nxt.phase = PH_PSTART;
          end else if (data_byte == CH_CR) begin
            res.kind = KIND_COMMAND; res.stop = 1'b1; nxt.phase = PH_LF;
          end else if (alnum) begin
            res.kind = KIND_COMMAND;
          end else begin
            fail = 1'b1;
          end
        end
        PH_PSTART: begin
          if (data_byte == CH_COLON) begin
            nxt.phase = PH_TSTART;
          end else if (regular && cur.param_count != PC_MAX) begin
            res.param_index = cur.param_count;
            nxt.param_count = cur.param_count + 8'd1;
            res.kind = KIND_MIDDLE; res.start = 1'b1; nxt.phase = PH_PARAM;
          end else begin
            fail = 1'b1;
          end
        end
        PH_PARAM: begin
          res.param_index = last_param;
          if (data_byte == CH_SPACE) begin
            res.kind = KIND_MIDDLE; res.stop = 1'b1; nxt.phase = PH_PSTART;
          end else if (data_byte == CH_CR) begin
            res.kind = KIND_MIDDLE; res.stop = 1'b1; nxt.phase = PH_LF;
          end else if (data_byte == CH_LF || data_byte == CH_NUL) begin
            fail = 1'b1;
          end else begin
            res.kind = KIND_MIDDLE;
          end
        end
        PH_TSTART: begin
          if (data_byte == CH_LF || data_byte == CH_NUL || cur.param_count == PC_MAX) begin
            fail = 1'b1;
          end else begin
            res.param_index = cur.param_count;
            nxt.param_count = cur.param_count + 8'd1;
            res.kind  = KIND_TRAIL;
            res.start = 1'b1;
            // An empty trailing parameter starts and ends on the CR byte.
            if (data_byte == CH_CR) begin
              res.stop  = 1'b1;
              nxt.phase = PH_LF;
            end else begin
              nxt.phase = PH_TRAIL;
            end
          end
        end
        PH_TRAIL: begin
          res.param_index = last_param;
          if (data_byte == CH_CR) begin
            res.kind = KIND_TRAIL; res.stop = 1'b1; nxt.phase = PH_LF;
          end else if (data_byte == CH_LF || data_byte == CH_NUL) begin
            fail = 1'b1;
          end else begin
            res.kind = KIND_TRAIL;
          end
        end
        PH_LF: begin
          if (data_byte == CH_LF) begin
            res.status       = ST_DONE;
            nxt.final_status = ST_DONE;
          end else begin
            fail = 1'b1;
          end
        end
      endcase
    end

    // A failing byte carries no token marks.
    if (fail) begin
      res.status       = ST_FAIL;
      nxt.final_status = ST_FAIL;
      res.kind         = KIND_NONE;
      res.start        = 1'b0;
      res.stop         = 1'b0;
      res.param_index  = 8'd0;
    end
  end

endmodule

>>> design/irc_message_line_parser.sv
// ----------------------------------------------------------------------------
// irc_message_line_parser
// Byte-serial checker of IRC message lines with token boundary marks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, operation, data_byte) takes one item
//   per cycle while in_stall is low: operation 0 feeds a byte of the line,
//   operation 1 clears the parser. Every item gives exactly one result item
//   on the output channel (out_valid, out_stall, status, token_kind,
//   token_start, token_end, param_index, byte_position).
//   Path: an accepted item is held in the input register; its result is
//   loaded into the output register, from which the receiver takes it.
//   Throughput: one item per cycle while in_stall is low, set by the state
//   update between the input register and the output register.
//   The configuration channel (cfg_valid, cfg_ready, max_line_length) is
//   always ready and writes the line length limit; write it only while idle.
//   Reset (rst, synchronous) empties both registers, clears the parse state
//   and sets the length limit to 512.
//   When the receiver stalls, the result holds; the input register stays
//   full and in_stall rises until the output register can be loaded again.
// ----------------------------------------------------------------------------
module irc_message_line_parser import irc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  // Output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [2:0]  token_kind,
  output logic        token_start,
  output logic        token_end,
  output logic [7:0]  param_index,
  output logic [9:0]  byte_position,
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  max_line_length
);

  `include "irc_message_line_parser_assert.svh"

  logic          line_limit;
  logic [9:0]    limit;
  logic          s1_valid;
  logic          s1_op;
  logic [7:0]    s1_byte;
  logic          s1_adv;
  parse_state_t  st;
  parse_state_t  st_next;
  parse_result_t res_next;
  parse_result_t res;

  assign cfg_ready  = 1'b1;
  assign line_limit = cfg_valid && cfg_ready;

  // Length limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= MAX_LEN_RESET;
    end else if (line_limit) begin
      limit <= max_line_length;
    end
  end

  // The input register moves on when the output register is free or drained.
  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_op   <= operation;
      s1_byte <= data_byte;
    end
  end

  // Per-item transition.
  irc_step u_step (
    .cur       (st),
    .op        (s1_op),
    .data_byte (s1_byte),
    .limit     (limit),
    .nxt       (st_next),
    .res       (res_next)
  );

  // Parse state advances once per item moved into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_CLEAR;
    end else if (s1_valid && s1_adv) begin
      st <= st_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      res <= res_next;
    end
  end

  assign status        = res.status;
  assign token_kind    = res.kind;
  assign token_start   = res.start;
  assign token_end     = res.stop;
  assign param_index   = res.param_index;
  assign byte_position = res.position;

  // A failure result carries no token marks.
  `IRC_ASSERT_SAME(a_fail_clean, out_valid && status == ST_FAIL,
    token_kind == KIND_NONE && !token_start && !token_end && param_index == 8'd0)

  // A prefix token can only start on the first byte of a line.
  `IRC_ASSERT_SAME(a_prefix_first, out_valid && token_start && token_kind == KIND_PREFIX,
    byte_position == 10'd0)

  // Once a status is held, fed bytes leave the count and status alone.
  `IRC_ASSERT_NEXT(a_hold,
    s1_valid && s1_adv && s1_op == OP_FEED && st.final_status != ST_CONT,
    $stable(st.byte_count) && $stable(st.final_status))

  // The byte count never passes the length limit while a line is parsed.
  `IRC_ASSERT_SAME(a_count_limit, !line_limit && st.final_status == ST_CONT,
    st.byte_count <= limit || st.byte_count == 10'd0)

endmodule
